// ===== rtl/asp_pkg.sv =====
package asp_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int MAX_OUT        = 64;
  localparam int FOUND_W        = $clog2(MAX_OUT + 1);

  localparam logic [15:0] FULL_LIFE  = 16'd32768;
  localparam logic [15:0] DECAY_RST  = 16'd256;
  localparam int          LOSS_SHIFT = 9;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_LIVE = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_ADD,
    ST_SCAN
  } state_t;

endpackage

// ===== rtl/aging_slot_pool_next_fit.sv =====
// Pool of SLOT_COUNT slots, each holding a remaining life in Q1.15, with a
// next-fit search hint. A beat with mode tick ages every live slot by
// (decay_rate * elapsed) >> 9, clamped at zero, and returns one beat with the
// live count. Mode add searches circularly from the hint for a dead slot,
// gives it full life and returns its index; with no dead slot, slot 0 is
// reused and overwrote_live is set. Mode scan returns one beat per live slot
// in index order (at most 64, the final one with tlast), or one beat of kind
// "none" when the pool is empty. Mode 3 is taken and dropped. The life values
// sit in a single-port-write, single-port-read memory, and one sequencer walks
// it one slot per cycle while the output register is not stalled (an add
// stops early at the first dead slot), and in_tready stays low while an item
// is in work. After reset a clearing pass writes every slot to zero before
// in_tready first rises. A finished result waits in an output register, and
// decay_rate may be written whenever the block is idle.
module aging_slot_pool_next_fit
  import asp_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,     // decay_rate
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // elapsed
  input  logic [1:0]  in_tuser,      // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // slot, life_left, live_count, overwrote_live, zero pad
  output logic [1:0]  out_tuser,     // kind
  output logic        out_tlast
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] CNT_END   = CW'(SLOT_COUNT);

  logic [15:0] life_mem [SLOT_COUNT];

  state_t              state_r, state_nxt;
  logic [15:0]         decay_r;
  logic [AW-1:0]       hint_r;
  logic [AW-1:0]       addr_r;
  logic [CW-1:0]       cnt_r;
  logic                dval_r;
  logic [AW-1:0]       daddr_r;
  logic [15:0]         rd_data_r;
  logic [22:0]         loss_r;
  logic [CW-1:0]       live_r;
  logic                hold_v_r;
  logic [AW-1:0]       hold_slot_r;
  logic [15:0]         hold_life_r;
  logic [FOUND_W-1:0]  found_r;
  logic                stop_r;

  logic                out_valid_r;
  logic [31:0]         out_data_r;
  logic [1:0]          out_kind_r;
  logic                out_last_r;

  logic                accept;
  logic [31:0]         product;
  logic                walk_done;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [15:0]         mem_wdata;
  logic                issue, fin, emit, go;
  logic                tick_live, add_found, capture;
  logic [1:0]          e_kind;
  logic [5:0]          e_slot;
  logic [15:0]         e_life;
  logic [6:0]          e_count;
  logic                e_over, e_last;
  logic [15:0]         tick_new;
  logic [CW+6:0]       live_ext;
  logic [AW+5:0]       daddr_ext, hold_ext;
  logic [AW-1:0]       addr_inc;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign product   = {16'd0, decay_r} * {16'd0, in_tdata};
  assign walk_done = (cnt_r == CNT_END) && !dval_r;
  assign live_ext  = {7'd0, live_r};
  assign daddr_ext = {6'd0, daddr_r};
  assign hold_ext  = {6'd0, hold_slot_r};
  assign addr_inc  = (addr_r == LAST_ADDR) ? '0 : addr_r + 1'b1;
  assign tick_new  = ({7'd0, rd_data_r} > loss_r) ? rd_data_r - loss_r[15:0] : 16'd0;
  assign go        = !(emit && out_valid_r && !out_tready);

  // sequencer outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = daddr_r;
    mem_wdata = 16'd0;
    issue     = 1'b0;
    fin       = 1'b0;
    emit      = 1'b0;
    tick_live = 1'b0;
    add_found = 1'b0;
    capture   = 1'b0;
    e_kind    = KIND_TICK;
    e_slot    = 6'd0;
    e_life    = 16'd0;
    e_count   = 7'd0;
    e_over    = 1'b0;
    e_last    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
      end
      ST_IDLE: begin
      end
      ST_TICK: begin
        if (walk_done) begin
          fin     = 1'b1;
          emit    = 1'b1;
          e_kind  = KIND_TICK;
          e_count = live_ext[6:0];
          e_last  = 1'b1;
        end else begin
          issue = (cnt_r != CNT_END);
          if (dval_r && rd_data_r != 16'd0) begin
            mem_we    = 1'b1;
            mem_wdata = tick_new;
            tick_live = (tick_new != 16'd0);
          end
        end
      end
      ST_ADD: begin
        if (walk_done) begin
          fin       = 1'b1;
          emit      = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = FULL_LIFE;
          e_kind    = KIND_ADD;
          e_over    = 1'b1;
          e_last    = 1'b1;
        end else if (dval_r && rd_data_r == 16'd0) begin
          fin       = 1'b1;
          emit      = 1'b1;
          add_found = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = FULL_LIFE;
          e_kind    = KIND_ADD;
          e_slot    = daddr_ext[5:0];
          e_last    = 1'b1;
        end else begin
          issue = (cnt_r != CNT_END);
        end
      end
      ST_SCAN: begin
        if (walk_done || stop_r) begin
          fin    = 1'b1;
          emit   = 1'b1;
          e_last = 1'b1;
          if (hold_v_r) begin
            e_kind = KIND_LIVE;
            e_slot = hold_ext[5:0];
            e_life = hold_life_r;
          end else begin
            e_kind = KIND_NONE;
          end
        end else begin
          issue = (cnt_r != CNT_END);
          if (dval_r && rd_data_r != 16'd0) begin
            capture = 1'b1;
            if (hold_v_r) begin
              emit   = 1'b1;
              e_kind = KIND_LIVE;
              e_slot = hold_ext[5:0];
              e_life = hold_life_r;
            end
          end
        end
      end
      default: begin
      end
    endcase
    mem_re = issue && go;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            MODE_TICK: state_nxt = ST_TICK;
            MODE_ADD:  state_nxt = ST_ADD;
            MODE_SCAN: state_nxt = ST_SCAN;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK, ST_ADD, ST_SCAN: begin
        if (fin && go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we && go) life_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= life_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      decay_r     <= DECAY_RST;
      hint_r      <= '0;
      addr_r      <= '0;
      cnt_r       <= '0;
      dval_r      <= 1'b0;
      live_r      <= '0;
      hold_v_r    <= 1'b0;
      found_r     <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) decay_r <= cfg_wdata;

      if (state_r == ST_CLEAR) addr_r <= addr_inc;

      if (accept) begin
        addr_r   <= (in_tuser == MODE_ADD) ? hint_r : '0;
        cnt_r    <= '0;
        dval_r   <= 1'b0;
        live_r   <= '0;
        hold_v_r <= 1'b0;
        found_r  <= '0;
        stop_r   <= 1'b0;
      end else if (go && state_r != ST_CLEAR && state_r != ST_IDLE) begin
        dval_r  <= issue;
        if (issue) begin
          addr_r <= addr_inc;
          cnt_r  <= cnt_r + 1'b1;
        end
        if (tick_live) live_r <= live_r + 1'b1;
        if (add_found) hint_r <= daddr_r;
        if (capture) begin
          hold_v_r <= 1'b1;
          found_r  <= found_r + 1'b1;
          if (found_r == FOUND_W'(MAX_OUT - 1)) stop_r <= 1'b1;
        end
      end

      if (emit && go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) loss_r <= product[31:LOSS_SHIFT];
    if (go && state_r != ST_CLEAR && state_r != ST_IDLE && !accept) begin
      daddr_r <= addr_r;
      if (capture) begin
        hold_slot_r <= daddr_r;
        hold_life_r <= rd_data_r;
      end
    end
    if (emit && go) begin
      out_data_r <= {2'd0, e_over, e_count, e_life, e_slot};
      out_kind_r <= e_kind;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_END)
    else $error("walk counter past pool size");

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= LAST_ADDR)
    else $error("search hint outside pool");

  a_stop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && stop_r) |-> found_r == FOUND_W'(MAX_OUT))
    else $error("scan stopped before list limit");

  a_add_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD && mem_we && go) |=> (state_r == ST_IDLE && $past(mem_wdata) == FULL_LIFE))
    else $error("add write did not end the item with full life");

endmodule

// ===== tb/sv/aging_slot_pool_next_fit_test.sv =====
`timescale 1ns / 100ps

module aging_slot_pool_next_fit_test;
  import asp_pkg::*;

  localparam int          SLOTS        = SLOT_COUNT_DEF;
  localparam logic [1:0]  MODE_IGNORED = 2'd3;
  localparam int          SETTLE       = 3 * SLOTS;
  localparam int          HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] elapsed;
  } pool_op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [15:0] life;
    logic [6:0]  count;
    logic        over;
    logic        last;
  } pool_beat_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // predicted pool state
  logic [15:0] mdl_life [SLOTS];
  logic [5:0]  mdl_hint;
  logic [15:0] mdl_decay;

  pool_op_t    op_queue[$];
  pool_beat_t  pending_beats[$];
  pool_op_t    next_op;
  pool_beat_t  want;
  logic [31:0] want_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int errors = 0;
  int beats_checked = 0;
  int n_tick = 0, n_add = 0, n_scan = 0, n_ignored = 0, n_overwrite = 0, n_cfg = 0;

  aging_slot_pool_next_fit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic predict_pool_op(input logic [1:0] mode, input logic [15:0] elapsed);
    logic [31:0] loss;
    logic [6:0]  live;
    logic [5:0]  s;
    bit          found;
    int          listed;
    pool_beat_t  b;
    loss = ({16'd0, mdl_decay} * {16'd0, elapsed}) >> LOSS_SHIFT;
    live = '0;
    found = 1'b0;
    listed = 0;
    b = '0;
    case (mode)
      MODE_TICK: begin
        n_tick++;
        for (int i = 0; i < SLOTS; i++) begin
          if (mdl_life[i] != 16'd0) begin
            mdl_life[i] = ({16'd0, mdl_life[i]} > loss) ? mdl_life[i] - loss[15:0] : 16'd0;
            if (mdl_life[i] != 16'd0) live++;
          end
        end
        b.kind = KIND_TICK;
        b.count = live;
        b.last = 1'b1;
        pending_beats.push_back(b);
      end
      MODE_ADD: begin
        n_add++;
        for (int n = 0; n < SLOTS; n++) begin
          s = mdl_hint + 6'(n);
          if (!found && mdl_life[s] == 16'd0) begin
            found = 1'b1;
            mdl_life[s] = FULL_LIFE;
            mdl_hint = s;
            b.slot = s;
          end
        end
        if (!found) begin
          mdl_life[0] = FULL_LIFE;
          b.over = 1'b1;
          n_overwrite++;
        end
        b.kind = KIND_ADD;
        b.last = 1'b1;
        pending_beats.push_back(b);
      end
      MODE_SCAN: begin
        n_scan++;
        for (int i = 0; i < SLOTS; i++) begin
          if (mdl_life[i] != 16'd0 && listed < MAX_OUT) begin
            b = '0;
            b.kind = KIND_LIVE;
            b.slot = 6'(i);
            b.life = mdl_life[i];
            pending_beats.push_back(b);
            listed++;
          end
        end
        if (listed == 0) begin
          b = '0;
          b.kind = KIND_NONE;
          b.last = 1'b1;
          pending_beats.push_back(b);
        end else begin
          pending_beats[$].last = 1'b1;
        end
      end
      default: n_ignored++;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_pool_op(in_tuser, in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = op_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_op.mode;
          in_tdata <= next_op.elapsed;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got kind %0d tdata %h last %0d",
                   $time, out_tuser, out_tdata, out_tlast);
          errors++;
        end else begin
          want = pending_beats.pop_front();
          want_data = {2'b00, want.over, want.count, want.life, want.slot};
          if (out_tuser !== want.kind || out_tdata !== want_data || out_tlast !== want.last) begin
            $display("%0t: mismatch, expected kind %0d slot %0d life %0d count %0d over %0d last %0d",
                     $time, want.kind, want.slot, want.life, want.count, want.over, want.last);
            $display("%0t:           actual kind %0d slot %0d life %0d count %0d over %0d last %0d pad %0d",
                     $time, out_tuser, out_tdata[5:0], out_tdata[21:6], out_tdata[28:22],
                     out_tdata[29], out_tlast, out_tdata[31:30]);
            errors++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_op(input logic [1:0] mode, input logic [15:0] elapsed);
    pool_op_t op;
    op.mode = mode;
    op.elapsed = elapsed;
    op_queue.push_back(op);
  endtask

  task automatic drain_pool();
    @(negedge clk);
    while (op_queue.size() != 0 || in_tvalid || pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_decay(input logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    mdl_decay = value;
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_ops(input int n);
    int made;
    int pick;
    int k;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        k = $urandom_range(1, 6);
        repeat (k) push_op(MODE_ADD, 16'($urandom));
        made += k;
      end else if (pick < 70) begin
        push_op(MODE_TICK, 16'($urandom) >> $urandom_range(15));
        made++;
      end else if (pick < 95) begin
        push_op(MODE_SCAN, 16'($urandom));
        made++;
      end else begin
        push_op(MODE_IGNORED, 16'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) mdl_life[i] = 16'd0;
    mdl_hint = '0;
    mdl_decay = DECAY_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty pool, ignored mode, tiny and full-scale decay
    push_op(MODE_SCAN, 16'h0000);
    push_op(MODE_IGNORED, 16'hffff);
    push_op(MODE_ADD, 16'hffff);
    push_op(MODE_ADD, 16'h0000);
    push_op(MODE_ADD, 16'h5a5a);
    push_op(MODE_SCAN, 16'hffff);
    push_op(MODE_TICK, 16'h0000);
    push_op(MODE_TICK, 16'h0001);
    push_op(MODE_SCAN, 16'h0000);
    push_op(MODE_TICK, 16'hffff);
    push_op(MODE_SCAN, 16'h0000);
    push_op(MODE_TICK, 16'h0002);
    push_op(MODE_SCAN, 16'h0000);
    push_op(MODE_ADD, 16'h0000);
    push_op(MODE_IGNORED, 16'h0000);
    drain_pool();

    write_decay(16'hffff);
    push_op(MODE_ADD, 16'h0000);
    push_op(MODE_TICK, 16'hffff);
    push_op(MODE_SCAN, 16'h0000);
    drain_pool();

    write_decay(16'h0000);
    push_op(MODE_ADD, 16'h0000);
    push_op(MODE_ADD, 16'h0000);
    push_op(MODE_TICK, 16'hffff);
    push_op(MODE_SCAN, 16'h0000);
    drain_pool();

    // fill the pool past full, no idling
    write_decay(DECAY_RST);
    repeat (SLOTS + 2) push_op(MODE_ADD, 16'($urandom));
    push_op(MODE_SCAN, 16'h0000);
    push_op(MODE_TICK, 16'h0100);
    random_ops(15);
    drain_pool();

    send_idle_pct = 87;
    write_decay(16'($urandom));
    random_ops(25);
    drain_pool();

    // receiver holds off long while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 87;
    write_decay(16'h0001);
    repeat (8) push_op(MODE_ADD, 16'h0000);
    push_op(MODE_SCAN, 16'h0000);
    random_ops(25);
    @(negedge clk);
    hold_req = HOLD_CYCLES;
    drain_pool();

    send_idle_pct = 6;
    recv_stall_pct = 6;
    write_decay(16'($urandom));
    random_ops(25);
    drain_pool();

    $display("covered %0d ticks, %0d adds (%0d onto a full pool), %0d scans, %0d ignored beats",
             n_tick, n_add, n_overwrite, n_scan, n_ignored);
    $display("under %0d decay settings and four idle mixes; %0d result beats checked",
             n_cfg, beats_checked);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("timeout with %0d beats outstanding", pending_beats.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
